// ===== design/ialu_pkg.sv =====
// ----------------------------------------------------------------------------
// ialu_pkg
// Shared types, opcodes and sizes of the integer ALU with result history.
// ----------------------------------------------------------------------------
`default_nettype none

package ialu_pkg;

	localparam int HISTORY_DEPTH = 10;
	localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);
	localparam int ADDR_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int DATA_W        = 32;
	localparam int DIV_STEPS     = DATA_W;
	localparam int CNT_W         = $clog2(DIV_STEPS);

	localparam logic [3:0] OP_ADD = 4'd0;
	localparam logic [3:0] OP_SUB = 4'd1;
	localparam logic [3:0] OP_MUL = 4'd2;
	localparam logic [3:0] OP_DIV = 4'd3;
	localparam logic [3:0] OP_POW = 4'd4;
	localparam logic [3:0] OP_AND = 4'd5;
	localparam logic [3:0] OP_OR  = 4'd6;
	localparam logic [3:0] OP_ABS = 4'd7;
	localparam logic [3:0] OP_SHR = 4'd8;
	localparam logic [3:0] OP_SHL = 4'd9;

	typedef struct packed {
		logic        [3:0]        req_type;
		logic signed [DATA_W-1:0] operand_a;
		logic signed [DATA_W-1:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result;
		logic signed [DATA_W-1:0] remainder;
		logic                     div_by_zero;
		logic                     invalid_op;
		logic                     saved;
		logic        [3:0]        history_count;
	} rsp_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result;
		logic signed [DATA_W-1:0] remainder;
		logic                     div_by_zero;
		logic                     invalid_op;
	} calc_t;

endpackage

`default_nettype wire

// ===== design/ialu_req_if.sv =====
// ----------------------------------------------------------------------------
// ialu_req_if
// Request channel: valid, ready and one operation beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ialu_req_if import ialu_pkg::*; ();
	logic valid;
	logic ready;
	req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/ialu_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ialu_rsp_if
// Response channel: valid, ready and one result beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ialu_rsp_if import ialu_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/ialu_ram.sv =====
// ----------------------------------------------------------------------------
// ialu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ialu_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== design/ialu_core.sv =====
// ----------------------------------------------------------------------------
// ialu_core
// Sequencer around one shared 33-bit adder: shift-add multiply, restoring
// divide and square-and-multiply power; logic and shifts are done directly.
// ----------------------------------------------------------------------------
`default_nettype none

module ialu_core import ialu_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire req_t  req,
	input  wire logic  take,
	output logic       ready,
	output logic       done,
	output calc_t      calc
);

	typedef enum logic [3:0] {
		S_IDLE, S_DABS, S_DIV, S_NEGQ, S_NEGR,
		S_MUL, S_PSTEP, S_PMUL, S_PSQR, S_DONE
	} state_t;

	state_t              state_q;
	logic [DATA_W:0]     p_q;
	logic [DATA_W-1:0]   m_q;
	logic [DATA_W-1:0]   n_q;
	logic [DATA_W-1:0]   base_q;
	logic [DATA_W-1:0]   exp_q;
	logic [DATA_W-1:0]   racc_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                qneg_q;
	logic                aneg_q;
	calc_t               calc_q;

	logic [DATA_W:0]     add_a;
	logic [DATA_W:0]     add_b;
	logic                add_sub;
	logic [DATA_W+1:0]   sum;
	logic [DATA_W:0]     shifted;
	logic [DATA_W-1:0]   prod;
	logic                mul_last;
	logic [DATA_W-1:0]   op_a;
	logic [DATA_W-1:0]   op_b;
	logic [4:0]          sh_cnt;
	logic [DATA_W-1:0]   pow_neg;

	assign op_a     = req.operand_a;
	assign op_b     = req.operand_b;
	assign shifted  = {p_q[DATA_W-1:0], n_q[DATA_W-1]};
	assign prod     = n_q[0] ? sum[DATA_W-1:0] : p_q[DATA_W-1:0];
	assign mul_last = (n_q[DATA_W-1:1] == '0);
	assign sh_cnt   = op_b[DATA_W-1] ? 5'd0 : ((|op_b[DATA_W-2:5]) ? 5'd31 : op_b[4:0]);

	always_comb begin
		if (op_a == 32'h0000_0001) begin
			pow_neg = 32'h0000_0001;
		end else if (op_a == 32'hFFFF_FFFF) begin
			pow_neg = op_b[0] ? 32'hFFFF_FFFF : 32'h0000_0001;
		end else begin
			pow_neg = '0;
		end
	end

	// route operands into the shared adder
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				case (req.req_type)
					OP_ADD: begin
						add_a = {1'b0, op_a};
						add_b = {1'b0, op_b};
					end
					OP_SUB: begin
						add_a   = {1'b0, op_a};
						add_b   = {1'b0, op_b};
						add_sub = 1'b1;
					end
					default: begin
						add_b   = {1'b0, op_a};
						add_sub = 1'b1;
					end
				endcase
			end
			S_DABS: begin
				add_b   = {1'b0, m_q};
				add_sub = 1'b1;
			end
			S_DIV: begin
				add_a   = shifted;
				add_b   = {1'b0, m_q};
				add_sub = 1'b1;
			end
			S_NEGQ: begin
				add_b   = {1'b0, n_q};
				add_sub = 1'b1;
			end
			S_NEGR: begin
				add_b   = {1'b0, p_q[DATA_W-1:0]};
				add_sub = 1'b1;
			end
			S_MUL, S_PMUL, S_PSQR: begin
				add_a = p_q;
				add_b = {1'b0, m_q};
			end
			default: begin
				add_a = '0;
			end
		endcase
	end

	assign sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (DATA_W+2)'(add_sub);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			p_q     <= '0;
			m_q     <= '0;
			n_q     <= '0;
			base_q  <= '0;
			exp_q   <= '0;
			racc_q  <= '0;
			cnt_q   <= '0;
			qneg_q  <= 1'b0;
			aneg_q  <= 1'b0;
			calc_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						calc_q.remainder   <= '0;
						calc_q.div_by_zero <= 1'b0;
						calc_q.invalid_op  <= 1'b0;
						state_q            <= S_DONE;
						unique case (req.req_type)
							OP_ADD, OP_SUB: calc_q.result <= sum[DATA_W-1:0];
							OP_MUL: begin
								p_q     <= '0;
								m_q     <= op_a;
								n_q     <= op_b;
								state_q <= S_MUL;
							end
							OP_DIV: begin
								if (op_b == '0) begin
									calc_q.div_by_zero <= 1'b1;
								end else begin
									p_q     <= '0;
									n_q     <= op_a[DATA_W-1] ? sum[DATA_W-1:0] : op_a;
									m_q     <= op_b;
									qneg_q  <= op_a[DATA_W-1] ^ op_b[DATA_W-1];
									aneg_q  <= op_a[DATA_W-1];
									cnt_q   <= '0;
									state_q <= S_DABS;
								end
							end
							OP_POW: begin
								if (op_b[DATA_W-1]) begin
									calc_q.result <= pow_neg;
								end else begin
									racc_q  <= DATA_W'(1);
									base_q  <= op_a;
									exp_q   <= op_b;
									state_q <= S_PSTEP;
								end
							end
							OP_AND: calc_q.result <= op_a & op_b;
							OP_OR:  calc_q.result <= op_a | op_b;
							OP_ABS: calc_q.result <= op_a[DATA_W-1] ? sum[DATA_W-1:0] : op_a;
							OP_SHR: calc_q.result <= req.operand_a >>> sh_cnt;
							OP_SHL: calc_q.result <= op_a << sh_cnt;
							default: calc_q.invalid_op <= 1'b1;
						endcase
					end
				end
				S_DABS: begin
					if (m_q[DATA_W-1]) begin
						m_q <= sum[DATA_W-1:0];
					end
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (sum[DATA_W+1]) begin
						p_q <= sum[DATA_W:0];
						n_q <= {n_q[DATA_W-2:0], 1'b1};
					end else begin
						p_q <= shifted;
						n_q <= {n_q[DATA_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= S_NEGQ;
					end
				end
				S_NEGQ: begin
					if (qneg_q) begin
						n_q <= sum[DATA_W-1:0];
					end
					state_q <= S_NEGR;
				end
				S_NEGR: begin
					calc_q.result    <= n_q;
					calc_q.remainder <= aneg_q ? sum[DATA_W-1:0] : p_q[DATA_W-1:0];
					state_q          <= S_DONE;
				end
				S_MUL: begin
					p_q <= {1'b0, prod};
					m_q <= {m_q[DATA_W-2:0], 1'b0};
					n_q <= {1'b0, n_q[DATA_W-1:1]};
					if (mul_last) begin
						calc_q.result <= prod;
						state_q       <= S_DONE;
					end
				end
				S_PSTEP: begin
					if (exp_q == '0) begin
						calc_q.result <= racc_q;
						state_q       <= S_DONE;
					end else begin
						p_q     <= '0;
						m_q     <= exp_q[0] ? racc_q : base_q;
						n_q     <= base_q;
						state_q <= exp_q[0] ? S_PMUL : S_PSQR;
					end
				end
				S_PMUL: begin
					p_q <= {1'b0, prod};
					m_q <= {m_q[DATA_W-2:0], 1'b0};
					n_q <= {1'b0, n_q[DATA_W-1:1]};
					if (mul_last) begin
						racc_q <= prod;
						if (exp_q[DATA_W-1:1] == '0) begin
							exp_q   <= '0;
							state_q <= S_PSTEP;
						end else begin
							p_q     <= '0;
							m_q     <= base_q;
							n_q     <= base_q;
							state_q <= S_PSQR;
						end
					end
				end
				S_PSQR: begin
					p_q <= {1'b0, prod};
					m_q <= {m_q[DATA_W-2:0], 1'b0};
					n_q <= {1'b0, n_q[DATA_W-1:1]};
					if (mul_last) begin
						base_q  <= prod;
						exp_q   <= {1'b0, exp_q[DATA_W-1:1]};
						state_q <= S_PSTEP;
					end
				end
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign ready = (state_q == S_IDLE);
	assign done  = (state_q == S_DONE);
	assign calc  = calc_q;

endmodule

`default_nettype wire

// ===== design/integer_alu_with_history.sv =====
// ----------------------------------------------------------------------------
// integer_alu_with_history
// 32-bit integer ALU with a result history store.
//
// One request beat carries an opcode and two signed operands; one response
// beat follows for each. All arithmetic runs through a single shared adder
// under a sequencer, and the request side is not ready until the current
// operation has finished. Add, sub, and, or, abs, shifts and invalid
// opcodes finish straight from the idle state; multiply takes one step per
// significant bit of operand_b; divide takes one step per quotient bit plus
// sign fix-up; power walks the exponent, running a multiply for each set bit
// and a squaring for each bit below the highest set one, in the same loop.
// A finished response waits in the output register while the next request
// is taken. On a zero divisor or unknown opcode the previous result is
// returned and flagged. Each response is written to the history store until
// HISTORY_DEPTH entries are held; history_count shows the low 4 bits of the
// fill level.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_alu_with_history import ialu_pkg::*; (
	input wire logic   clk,
	input wire logic   arst_n,
	ialu_req_if.sink   req,
	ialu_rsp_if.source rsp
);

	logic              core_ready;
	logic              core_done;
	logic              start;
	logic              take;
	logic              save;
	calc_t             calc;
	logic [DATA_W-1:0] final_res;
	logic [FILL_W-1:0] fill_next;
	logic              out_valid_q;
	rsp_t              rsp_q;
	logic [DATA_W-1:0] last_q;
	logic [FILL_W-1:0] fill_q;

	assign start     = req.valid && core_ready;
	assign take      = core_done && (!out_valid_q || rsp.ready);
	assign final_res = (calc.div_by_zero || calc.invalid_op) ? last_q : calc.result;
	assign save      = (fill_q < FILL_W'(HISTORY_DEPTH));
	assign fill_next = fill_q + FILL_W'(save);

	ialu_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req.payload),
		.take   (take),
		.ready  (core_ready),
		.done   (core_done),
		.calc   (calc)
	);

	ialu_ram #(
		.WIDTH (DATA_W),
		.DEPTH (HISTORY_DEPTH)
	) u_history (
		.clk   (clk),
		.we    (take && save),
		.waddr (fill_q[ADDR_W-1:0]),
		.wdata (final_res),
		.raddr ('0),
		.rdata ()
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_q      <= '0;
			fill_q      <= '0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
				last_q      <= final_res;
				fill_q      <= fill_next;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q.result        <= final_res;
			rsp_q.remainder     <= calc.remainder;
			rsp_q.div_by_zero   <= calc.div_by_zero;
			rsp_q.invalid_op    <= calc.invalid_op;
			rsp_q.saved         <= save;
			rsp_q.history_count <= 4'(fill_next);
		end
	end

	assign req.ready   = core_ready;
	assign rsp.valid   = out_valid_q;
	assign rsp.payload = rsp_q;

endmodule

`default_nettype wire

// ===== design/ialu_checker.sv =====
// ----------------------------------------------------------------------------
// ialu_checker
// Port-level checks on the integer ALU, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ialu_checker import ialu_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire rsp_t out_payload
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request side ready right after an accepted beat");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload))
		else $error("stalled response beat changed or dropped");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_payload.div_by_zero && out_payload.invalid_op))
		else $error("both error flags set on one response");

	a_error_no_rem: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_payload.div_by_zero || out_payload.invalid_op)
		|-> out_payload.remainder == '0)
		else $error("nonzero remainder on an error response");

endmodule

bind integer_alu_with_history ialu_checker u_ialu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.out_payload (rsp.payload)
);

`default_nettype wire
